// ----- src/cofd_pkg.sv -----
// Shared constants for the cofactor determinant block.
// Used by the front end, the expansion engine and the top level.
package cofd_pkg;

   localparam int ORDER_W               = 3;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd4;
   localparam int MAX_ORDER_DEFAULT     = 4;
   localparam int ELEMENT_WIDTH_DEFAULT = 12;
   localparam int ACC_W                 = 64;
   localparam int DET_W                 = 50;
   localparam int QUEUE_DEPTH           = 4;

endpackage

// ----- src/cofd_fifo.sv -----
// Small synchronous queue between the loader front end and the expansion engine.
// Does not import cofd_pkg; its width and depth are passed in by the top level.
module cofd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = (fill_ff != (PTR_W+1)'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/cofd_front.sv -----
// Loader front end: holds the matrix order register, counts elements and tags each one
// with its store index and an end-of-matrix mark. Depends on cofd_pkg.
module cofd_front import cofd_pkg::*; #(
   parameter int MAX_ORDER     = MAX_ORDER_DEFAULT,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT,
   parameter int IDX_W         = 4,
   parameter int ENTRY_W       = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [ORDER_W-1:0]              csr_write_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [ELEMENT_WIDTH-1:0] req_element,
   output logic                            push_valid,
   input  logic                            push_ready,
   output logic [ENTRY_W-1:0]              push_data
);

   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef struct packed {
      logic signed [ELEMENT_WIDTH-1:0] element;
      logic [IDX_W-1:0]                index;
      logic                            last;
      logic [ORDER_W-1:0]              order;
   } entry_type;

   logic [ORDER_W-1:0] order_ff, order_in;
   logic [CNT_W-1:0]   load_count_ff, load_count_in;
   logic [ORDER_W-1:0] order_use;
   logic [5:0]         total_wide;
   logic [CNT_W-1:0]   total;
   logic [CNT_W-1:0]   slot;
   logic [CNT_W:0]     slot_next;
   logic               last_elem;
   entry_type          entry;

   always_comb begin
      order_use = order_ff;
      if (order_ff == '0) begin
         order_use = ORDER_W'(1);
      end else if (order_ff > ORDER_W'(MAX_ORDER)) begin
         order_use = ORDER_W'(MAX_ORDER);
      end
   end

   assign total_wide = {3'b000, order_use} * {3'b000, order_use};
   assign total      = total_wide[CNT_W-1:0];
   assign slot       = (load_count_ff >= total) ? '0 : load_count_ff;
   assign slot_next  = {1'b0, slot} + 1'b1;
   assign last_elem  = (slot_next >= {1'b0, total});

   always_comb begin
      entry.element = req_element;
      entry.index   = slot[IDX_W-1:0];
      entry.last    = last_elem;
      entry.order   = order_use;
   end

   assign push_data  = entry;
   assign push_valid = req_valid;
   assign req_ready  = push_ready;

   always_comb begin
      order_in      = order_ff;
      load_count_in = load_count_ff;
      // A register write drops any partial load.
      if (csr_write_enable) begin
         order_in      = csr_write_data;
         load_count_in = '0;
      end else if (req_valid && push_ready) begin
         load_count_in = last_elem ? '0 : slot_next[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff      <= ORDER_RESET;
         load_count_ff <= '0;
      end else begin
         order_ff      <= order_in;
         load_count_ff <= load_count_in;
      end
   end

endmodule

// ----- src/cofd_engine.sv -----
// Expansion engine: stores elements, then expands the determinant along rows over
// column subsets on one shared multiplier. Depends on cofd_pkg.
module cofd_engine import cofd_pkg::*; #(
   parameter int MAX_ORDER     = MAX_ORDER_DEFAULT,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT,
   parameter int IDX_W         = 4,
   parameter int ENTRY_W       = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  logic [ENTRY_W-1:0]      pop_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [DET_W-1:0] rsp_determinant
);

   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int SUB_W = MAX_ORDER;
   localparam int COL_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int MUL_W = ELEMENT_WIDTH + 33;

   typedef struct packed {
      logic signed [ELEMENT_WIDTH-1:0] element;
      logic [IDX_W-1:0]                index;
      logic                            last;
      logic [ORDER_W-1:0]              order;
   } entry_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ISSUE = 6'b000010,
      ST_LO    = 6'b000100,
      ST_HI    = 6'b001000,
      ST_ACC   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   function automatic logic [ORDER_W-1:0] pop_count(input logic [SUB_W-1:0] m);
      logic [ORDER_W-1:0] c;
      c = '0;
      for (int i = 0; i < SUB_W; i++) begin
         c = c + ORDER_W'(m[i]);
      end
      return c;
   endfunction

   function automatic logic [COL_W-1:0] lowest_bit(input logic [SUB_W-1:0] m);
      logic [COL_W-1:0] c;
      c = '0;
      for (int i = SUB_W - 1; i >= 0; i--) begin
         if (m[i]) begin
            c = COL_W'(i);
         end
      end
      return c;
   endfunction

   entry_type                 entry;
   state_type                 state_ff, state_in;
   logic [ORDER_W-1:0]        n_ff, n_in;
   logic [SUB_W-1:0]          subset_ff, subset_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic                      sign_ff, sign_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [ACC_W-1:0]          lo_ff, lo_in;
   logic [31:0]               hi_ff, hi_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DET_W-1:0]   rsp_det_ff, rsp_det_in;

   logic signed [ELEMENT_WIDTH-1:0] elem_mem [DEPTH];
   logic [ACC_W-1:0]                minor_mem [1 << SUB_W];
   logic signed [ELEMENT_WIDTH-1:0] a_ff;
   logic [ACC_W-1:0]                d_ff;

   logic [SUB_W-1:0]          full_mask;
   logic [SUB_W-1:0]          rest;
   logic [COL_W-1:0]          first_col, next_col, rd_col;
   logic [ORDER_W-1:0]        row;
   logic [5:0]                elem_addr_wide;
   logic [IDX_W-1:0]          elem_addr;
   logic [SUB_W-1:0]          minor_addr;
   logic                      rd_en, mem_we, store_we;
   logic [31:0]               mul_b;
   logic signed [MUL_W-1:0]   mul_out;
   logic [ACC_W-1:0]          term, acc_next;

   assign entry = pop_data;

   assign full_mask = ~({SUB_W{1'b1}} << n_ff);
   assign first_col = lowest_bit(subset_ff);

   // Columns of the current subset above the one just used.
   always_comb begin
      for (int i = 0; i < SUB_W; i++) begin
         rest[i] = subset_ff[i] && (i > int'(col_ff));
      end
   end
   assign next_col = lowest_bit(rest);

   // A subset of k columns is expanded on row n-k, so the full set lands on the first row.
   assign row            = n_ff - pop_count(subset_ff);
   assign elem_addr_wide = {3'b000, row} * {3'b000, n_ff} + 6'(rd_col);
   assign elem_addr      = elem_addr_wide[IDX_W-1:0];
   assign minor_addr     = subset_ff ^ (SUB_W'(1) << rd_col);

   // The 64-bit minor is multiplied in two 32-bit halves on the same multiplier.
   assign mul_b    = (state_ff == ST_LO) ? d_ff[31:0] : d_ff[63:32];
   assign mul_out  = a_ff * $signed({1'b0, mul_b});
   assign term     = lo_ff + {hi_ff, 32'h0000_0000};
   assign acc_next = sign_ff ? (acc_ff - term) : (acc_ff + term);

   assign pop_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_determinant = rsp_det_ff;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      subset_in    = subset_ff;
      col_in       = col_ff;
      sign_in      = sign_ff;
      acc_in       = acc_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_det_in   = rsp_det_ff;
      rd_en        = 1'b0;
      rd_col       = first_col;
      mem_we       = 1'b0;
      store_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               store_we = 1'b1;
               if (entry.last) begin
                  n_in      = entry.order;
                  subset_in = SUB_W'(1);
                  state_in  = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            rd_en    = 1'b1;
            rd_col   = first_col;
            col_in   = first_col;
            acc_in   = '0;
            sign_in  = 1'b0;
            state_in = ST_LO;
         end
         ST_LO: begin
            lo_in    = ACC_W'(mul_out);
            state_in = ST_HI;
         end
         ST_HI: begin
            hi_in    = mul_out[31:0];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_next;
            if (rest != '0) begin
               rd_en    = 1'b1;
               rd_col   = next_col;
               col_in   = next_col;
               sign_in  = !sign_ff;
               state_in = ST_LO;
            end else begin
               mem_we = 1'b1;
               if (subset_ff == full_mask) begin
                  state_in = ST_DONE;
               end else begin
                  subset_in = subset_ff + 1'b1;
                  state_in  = ST_ISSUE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_det_in   = acc_ff[DET_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      subset_ff  <= subset_in;
      col_ff     <= col_in;
      sign_ff    <= sign_in;
      acc_ff     <= acc_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      rsp_det_ff <= rsp_det_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         elem_mem[entry.index] <= entry.element;
      end
      if (rd_en) begin
         a_ff <= elem_mem[elem_addr];
      end
   end

   // The empty column set has a minor of one.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         minor_mem[subset_ff] <= acc_next;
      end
      if (rd_en) begin
         d_ff <= (minor_addr == '0) ? ACC_W'(1) : minor_mem[minor_addr];
      end
   end

   a_col_in_subset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LO || state_ff == ST_HI || state_ff == ST_ACC) |-> subset_ff[col_ff])
      else $error("expansion column is not a member of the current subset");

   a_subset_in_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ((subset_ff & ~full_mask) == '0))
      else $error("column subset reaches beyond the matrix order");

   a_order_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (n_ff >= ORDER_W'(1) && n_ff <= ORDER_W'(MAX_ORDER)))
      else $error("matrix order out of range during expansion");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) |=>
         (rsp_valid_ff && rsp_det_ff == $past(acc_ff[DET_W-1:0])))
      else $error("finished determinant was not loaded into the output register");

endmodule

// ----- src/cofactor_determinant.sv -----
// Cofactor determinant block, top level.
//
// Elements of an n x n signed matrix arrive on the req_ channel in row-major order,
// one element per transfer. The order n is written through csr_write_enable and
// csr_write_data; 0 counts as 1 and values above MAX_ORDER count as MAX_ORDER, and a
// write restarts loading. After the last of the n*n elements the determinant, wrapped
// at 64 bits and cut to 50, appears as one transfer on the rsp_ channel.
// A front end tags each element and pushes it into a four-entry queue; the engine
// stores elements and, after the last one, expands over all column subsets with one
// shared multiplier, taking each product term through a low half, a high half and an
// accumulate state, with an issue state ahead of each subset. A matrix of order n
// needs n*2^(n-1) product terms over 2^n-1 subsets.
// While expanding the engine takes no element, so req_ready falls once the queue fills.
// The result sits in an output register; a stalled receiver keeps it there and the
// block goes on loading the next matrix meanwhile. Reset is synchronous and returns
// the order register to 4 with an empty load and no pending result.
module cofactor_determinant import cofd_pkg::*; #(
   parameter int MAX_ORDER     = MAX_ORDER_DEFAULT,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [ORDER_W-1:0]              csr_write_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [ELEMENT_WIDTH-1:0] req_element,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [DET_W-1:0]         rsp_determinant
);

   localparam int DEPTH   = MAX_ORDER * MAX_ORDER;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = ELEMENT_WIDTH + IDX_W + 1 + ORDER_W;

   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   cofd_front #(
      .MAX_ORDER     (MAX_ORDER),
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .IDX_W         (IDX_W),
      .ENTRY_W       (ENTRY_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_element      (req_element),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   cofd_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   cofd_engine #(
      .MAX_ORDER     (MAX_ORDER),
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .IDX_W         (IDX_W),
      .ENTRY_W       (ENTRY_W)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_determinant (rsp_determinant)
   );

endmodule

// ----- tb/sv/cofd_checker.sv -----
`timescale 1ns / 100ps
// Checker for the cofactor determinant block: follows order writes and element transfers,
// predicts each determinant and compares it with the transfers on the rsp_ channel.
// Depends on cofd_pkg for the order, element, accumulator and result widths.
module cofd_checker import cofd_pkg::*; (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [ORDER_W-1:0]                      csr_write_data,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic signed [ELEMENT_WIDTH_DEFAULT-1:0] req_element,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic signed [DET_W-1:0]                 rsp_determinant,
   input  logic                                    run_complete,
   output int                                      fail_count,
   output int                                      expected_pending
);

   localparam int EW    = ELEMENT_WIDTH_DEFAULT;
   localparam int MAXN  = MAX_ORDER_DEFAULT;
   localparam int CELLS = MAXN * MAXN;

   typedef logic [ACC_W-1:0] word_type;
   typedef word_type matrix_type [CELLS];

   logic [ORDER_W-1:0]      order_reg;
   int unsigned             fill_count;
   matrix_type              element_store;
   logic signed [DET_W-1:0] determinant_expected_q [$];
   logic                    leftovers_checked;
   int                      failures = 0;

   // A zero order counts as one, and anything above the largest order counts as it.
   function automatic int unsigned effective_order(input logic [ORDER_W-1:0] value);
      if (value == '0) return 1;
      if (value > MAXN) return MAXN;
      return int'(value);
   endfunction

   // Closed form for a 3x3 matrix stored row-major with a stride of three.
   function automatic word_type det3_of(input matrix_type m);
      return m[0] * (m[4] * m[8] - m[5] * m[7])
           - m[1] * (m[3] * m[8] - m[6] * m[5])
           + m[2] * (m[3] * m[7] - m[4] * m[6]);
   endfunction

   // All products wrap at the accumulator width, as the block's arithmetic does.
   function automatic word_type predict_determinant(input matrix_type m, input int unsigned n);
      word_type   sum;
      word_type   sub;
      matrix_type minor;
      int         k;
      case (n)
         1: return m[0];
         2: return m[0] * m[3] - m[1] * m[2];
         3: return det3_of(m);
         default: begin
            sum = '0;
            for (int c = 0; c < 4; c++) begin
               k = 0;
               for (int i = 1; i < 4; i++) begin
                  for (int j = 0; j < 4; j++) begin
                     if (j != c) begin
                        minor[k] = m[i * 4 + j];
                        k++;
                     end
                  end
               end
               sub = det3_of(minor);
               if (c % 2) sum = sum - m[c] * sub;
               else sum = sum + m[c] * sub;
            end
            return sum;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      word_type                det;
      int unsigned             n;
      int unsigned             total;
      int unsigned             slot;
      logic signed [DET_W-1:0] wanted;
      if (reset) begin
         order_reg = ORDER_RESET;
         fill_count = 0;
         determinant_expected_q.delete();
         leftovers_checked = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (determinant_expected_q.size() == 0) begin
               $display("%0t: unexpected determinant transfer, actual %0d, none expected",
                        $time, rsp_determinant);
               failures++;
            end else begin
               wanted = determinant_expected_q.pop_front();
               if (rsp_determinant !== wanted) begin
                  $display("%0t: determinant mismatch, expected %0d, actual %0d",
                           $time, wanted, rsp_determinant);
                  failures++;
               end
            end
         end

         // A write of the order also drops any partial load.
         if (csr_write_enable) begin
            order_reg = csr_write_data;
            fill_count = 0;
         end

         if (req_valid && req_ready) begin
            n = effective_order(order_reg);
            total = n * n;
            slot = fill_count;
            if (slot >= total) slot = 0;
            element_store[slot] = {{(ACC_W - EW){req_element[EW-1]}}, req_element};
            slot++;
            if (slot >= total) begin
               fill_count = 0;
               det = predict_determinant(element_store, n);
               determinant_expected_q.push_back(det[DET_W-1:0]);
            end else begin
               fill_count = slot;
            end
         end

         if (run_complete && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (determinant_expected_q.size() != 0) begin
               $display("%0t: %0d expected determinant(s) never arrived, next expected %0d",
                        $time, determinant_expected_q.size(), determinant_expected_q[0]);
               failures += determinant_expected_q.size();
            end
         end
      end
      fail_count       <= failures;
      expected_pending <= determinant_expected_q.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the cofactor determinant testbench: clock, reset, order writes, element stimulus,
// receiver back-pressure and the verdict. Depends on cofd_pkg, the block and cofd_checker.
module tb_top;
   import cofd_pkg::*;

   localparam int EW               = ELEMENT_WIDTH_DEFAULT;
   localparam int TARGET_ITEMS     = 650;
   localparam int SETTLE_CYCLES    = 250;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int LIMIT_CYCLES     = 500000;
   localparam logic [EW-1:0] ELEM_MIN = {1'b1, {(EW-1){1'b0}}};
   localparam logic [EW-1:0] ELEM_MAX = {1'b0, {(EW-1){1'b1}}};

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_write_enable;
   logic [ORDER_W-1:0]      csr_write_data;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [EW-1:0]    req_element;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [DET_W-1:0] rsp_determinant;
   logic                    run_complete;

   int          fail_count;
   int          expected_pending;
   int          items_sent        = 0;
   bit          sender_gaps       = 1'b0;
   bit          long_hold_request = 1'b0;
   int unsigned cycle_count       = 0;

   always #5 clock = ~clock;

   cofactor_determinant dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_element      (req_element),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_determinant  (rsp_determinant)
   );

   cofd_checker det_monitor (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_element      (req_element),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_determinant  (rsp_determinant),
      .run_complete     (run_complete),
      .fail_count       (fail_count),
      .expected_pending (expected_pending)
   );

   // Half the time no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [EW-1:0] random_element();
      logic signed [EW-1:0] near_zero;
      case ($urandom_range(0, 9))
         0: return ELEM_MIN;
         1: return ELEM_MAX;
         2: begin
            near_zero = EW'($urandom_range(0, 6));
            return near_zero - EW'(3);
         end
         default: return EW'($urandom);
      endcase
   endfunction

   // Offers one element and returns after the edge of its transfer, or after a random gap when sender gaps are on.
   task automatic send_element(input logic [EW-1:0] value);
      int gap;
      req_valid   <= 1'b1;
      req_element <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (sender_gaps) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_order(input logic [ORDER_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Waits for every expected determinant, then lets any expansion or queued element
   // still inside the block run out before the order may be written.
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: ready in runs of random length broken by gaps, with one long hold-off.
   initial begin
      int run;
      int gap;
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (long_hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin
      int                 n;
      int                 matrices;
      logic [ORDER_W-1:0] order_value;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_valid        <= 1'b0;
      req_element      <= '0;
      run_complete     <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Order 4 from reset: a sign pattern of extreme elements gives a near-largest result.
      for (int i = 0; i < 16; i++) begin
         send_element(($countones((i / 4) & (i % 4)) % 2) ? ELEM_MIN : ELEM_MAX);
      end
      settle_block();

      // A zero order counts as one.
      write_order(3'd0);
      send_element(ELEM_MAX);
      send_element(ELEM_MIN);
      settle_block();

      write_order(3'd2);
      send_element(ELEM_MAX);
      send_element(ELEM_MIN);
      send_element(ELEM_MIN);
      send_element(ELEM_MAX);
      settle_block();

      // A partial load that the next order write must drop.
      write_order(3'd3);
      send_element(ELEM_MIN);
      send_element(ELEM_MAX);

      for (int phase = 0; items_sent < TARGET_ITEMS; phase++) begin
         settle_block();
         if (phase == 1) begin
            // Long receiver hold-off while full matrices keep coming, so the block backs up.
            order_value = 3'd4;
            matrices = 6;
            sender_gaps = 1'b0;
            long_hold_request = 1'b1;
         end else begin
            order_value = ORDER_W'($urandom_range(0, 7));
            matrices = $urandom_range(1, 6);
            sender_gaps = ($urandom_range(0, 3) != 0);
         end
         write_order(order_value);
         n = (order_value == '0) ? 1 : ((int'(order_value) > MAX_ORDER_DEFAULT) ?
                                        MAX_ORDER_DEFAULT : int'(order_value));
         if (n == 1) matrices = matrices * 4;
         repeat (matrices * n * n) send_element(random_element());
         if (n > 1 && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, n * n - 1)) send_element(random_element());
         end
      end

      settle_block();
      run_complete <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- cofactor_determinant.f -----
src/cofd_pkg.sv
src/cofd_fifo.sv
src/cofd_front.sv
src/cofd_engine.sv
src/cofactor_determinant.sv
tb/sv/cofd_checker.sv
tb/sv/tb_top.sv
